// ===== sv/kwm_pkg.sv =====
package kwm_pkg;

  // default sizing
  localparam int unsigned LIST_COUNT_DEF = 8;
  localparam int unsigned CAPACITY_DEF   = 64;

  // field widths
  localparam int unsigned LIST_NUM_W = 3;
  localparam int unsigned VALUE_W    = 32;

  // stream widths
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 32;
  localparam int unsigned M_TUSER_W = 2;

  // bit positions inside m_axis_tuser
  localparam int unsigned M_TUSER_EMPTY = 0;
  localparam int unsigned M_TUSER_OVF   = 1;

endpackage

// ===== sv/kwm_ram.sv =====
module kwm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== sv/k_way_sorted_merge_top.sv =====
// K-way sorted merge. Each input item may carry one element (tuser) for source list
// tdata[2:0]; elements are appended to per-list chains in a shared store of CAPACITY
// entries, one item per cycle. An item with tlast set ends the set (its element, if any,
// is stored first) and starts the merge: the smallest current list head is emitted each
// time, the lowest list number winning ties, until every list is drained; the final
// result carries tlast. An empty set yields one result with the empty flag in tuser[0].
// Elements arriving with the store full are dropped and tuser[1] is set on every result
// of that set; list numbers at or above LIST_COUNT are ignored. Input is not accepted
// during the merge. Each result needs a scan of all list heads through the head memory
// and the value memory (one list per cycle, then the two reads and the last compare
// drain), then an emit state and a state that advances the chosen list through the link
// memory; a stalled output holds the emit state. Store state lives in four one-port-read
// RAMs (values, links, heads, tails); only the per-list valid bits are flops, so no
// clearing pass is needed.
module k_way_sorted_merge_top #(
  parameter int unsigned LIST_COUNT = kwm_pkg::LIST_COUNT_DEF,
  parameter int unsigned CAPACITY   = kwm_pkg::CAPACITY_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [2:0] list_number, [34:3] element_value, [39:35] zero
  input  logic [kwm_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] carries_element
  input  logic                           s_axis_tuser_i,
  // end_of_set
  input  logic                           s_axis_tlast_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [31:0] merged_value
  output logic [kwm_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  // [0] set_empty, [1] overflowed
  output logic [kwm_pkg::M_TUSER_W-1:0]  m_axis_tuser_o,
  // last_of_run
  output logic                           m_axis_tlast_o
);

  localparam int unsigned LW  = $clog2(LIST_COUNT);
  localparam int unsigned AW  = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned SW  = $clog2(LIST_COUNT + 1);
  localparam int unsigned LNW = (SW > kwm_pkg::LIST_NUM_W) ? SW : kwm_pkg::LIST_NUM_W;
  localparam int unsigned VW  = kwm_pkg::VALUE_W;

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_POP   = 3'd2;
  localparam logic [2:0] ST_LINK  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [LIST_COUNT-1:0] hvld_q, hvld_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  ovf_q, ovf_d;
  logic [CW-1:0]         rem_q, rem_d;
  logic [SW-1:0]         sc_q, sc_d;
  logic                  lk_pend_q, lk_pend_d;
  logic [AW-1:0]         lk_slot_q;
  logic                  p1_vld_q, p1_vld_d;
  logic [LW-1:0]         p1_list_q;
  logic                  p2_vld_q;
  logic [LW-1:0]         p2_list_q;
  logic [AW-1:0]         p2_head_q;
  logic                  best_vld_q, best_vld_d;
  logic [LW-1:0]         best_q;
  logic [AW-1:0]         best_head_q;
  logic [VW-1:0]         best_val_q;
  logic                  m_valid_q, m_valid_d;
  logic [VW-1:0]         m_data_q;
  logic                  m_last_q, m_empty_q, m_ovf_q;

  logic [kwm_pkg::LIST_NUM_W-1:0] in_list;
  logic [VW-1:0]         in_val;
  logic [LNW-1:0]        list_ext;
  logic                  in_range;
  logic [LW-1:0]         in_idx;
  logic                  s_acc, room, do_store, do_drop;
  logic [AW-1:0]         slot;
  logic [CW-1:0]         cnt_after;
  logic                  issue, take, out_free, emit_pop, emit_empty, list_done;
  logic [LW-1:0]         sc_idx;

  logic                  head_we;
  logic [LW-1:0]         head_waddr;
  logic [AW-1:0]         head_wdata, head_rdata;
  logic                  tail_re;
  logic [LW-1:0]         tail_raddr;
  logic [AW-1:0]         tail_rdata, link_rdata;
  logic [VW-1:0]         value_rdata;

  // input decode
  assign in_list  = s_axis_tdata_i[kwm_pkg::LIST_NUM_W-1:0];
  assign in_val   = s_axis_tdata_i[kwm_pkg::LIST_NUM_W +: VW];
  assign list_ext = LNW'(in_list);
  assign in_range = list_ext < LNW'(LIST_COUNT);
  assign in_idx   = list_ext[LW-1:0];

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign s_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign room      = cnt_q < CW'(CAPACITY);
  assign do_store  = s_acc && s_axis_tuser_i && in_range && room;
  assign do_drop   = s_acc && s_axis_tuser_i && in_range && !room;
  assign slot      = cnt_q[AW-1:0];
  assign cnt_after = cnt_q + CW'(do_store);

  // scan control
  assign sc_idx    = sc_q[LW-1:0];
  assign issue     = (state_q == ST_SCAN) && (sc_q < SW'(LIST_COUNT));
  assign p1_vld_d  = issue && hvld_q[sc_idx];
  assign take      = p2_vld_q && (!best_vld_q || ($signed(value_rdata) < $signed(best_val_q)));

  assign out_free   = !m_valid_q || m_axis_tready_i;
  assign emit_pop   = (state_q == ST_POP) && out_free;
  assign emit_empty = (state_q == ST_EMPTY) && out_free;
  // chosen entry was its list's tail: the list is now empty
  assign list_done  = (tail_rdata == best_head_q);

  assign lk_pend_d = do_store && hvld_q[in_idx];

  // head memory: new head on first element of a list, next link on advance
  always_comb begin
    head_we    = 1'b0;
    head_waddr = in_idx;
    head_wdata = slot;
    if (state_q == ST_LINK) begin
      head_we    = !list_done;
      head_waddr = best_q;
      head_wdata = link_rdata;
    end else if (do_store && !hvld_q[in_idx]) begin
      head_we = 1'b1;
    end
  end

  assign tail_re    = do_store || emit_pop;
  assign tail_raddr = (state_q == ST_POP) ? best_q : in_idx;

  kwm_ram #(.Width(VW), .Depth(CAPACITY)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (do_store),
    .waddr_i (slot),
    .wdata_i (in_val),
    .re_i    (p1_vld_q),
    .raddr_i (head_rdata),
    .rdata_o (value_rdata)
  );

  // link written in the cycle after the store, once the old tail has been read
  kwm_ram #(.Width(AW), .Depth(CAPACITY)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lk_pend_q),
    .waddr_i (tail_rdata),
    .wdata_i (lk_slot_q),
    .re_i    (emit_pop),
    .raddr_i (best_head_q),
    .rdata_o (link_rdata)
  );

  kwm_ram #(.Width(AW), .Depth(LIST_COUNT)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .re_i    (issue),
    .raddr_i (sc_idx),
    .rdata_o (head_rdata)
  );

  kwm_ram #(.Width(AW), .Depth(LIST_COUNT)) u_tail_ram (
    .clk_i   (clk_i),
    .we_i    (do_store),
    .waddr_i (in_idx),
    .wdata_i (slot),
    .re_i    (tail_re),
    .raddr_i (tail_raddr),
    .rdata_o (tail_rdata)
  );

  always_comb begin
    state_d    = state_q;
    hvld_d     = hvld_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    rem_d      = rem_q;
    sc_d       = sc_q;
    best_vld_d = best_vld_q || take;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    if (emit_pop || emit_empty) begin
      m_valid_d = 1'b1;
    end
    unique case (state_q)
      ST_LOAD: begin
        if (do_store) begin
          hvld_d[in_idx] = 1'b1;
          cnt_d          = cnt_after;
        end
        if (do_drop) begin
          ovf_d = 1'b1;
        end
        if (s_acc && s_axis_tlast_i) begin
          sc_d       = '0;
          best_vld_d = 1'b0;
          rem_d      = cnt_after;
          state_d    = (cnt_after == '0) ? ST_EMPTY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          sc_d = sc_q + SW'(1);
        end else if (!p1_vld_q && !p2_vld_q) begin
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        if (emit_pop) begin
          rem_d   = rem_q - CW'(1);
          state_d = ST_LINK;
        end
      end
      ST_LINK: begin
        if (list_done) begin
          hvld_d[best_q] = 1'b0;
        end
        sc_d       = '0;
        best_vld_d = 1'b0;
        if (rem_q == '0) begin
          hvld_d  = '0;
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = ST_LOAD;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_EMPTY: begin
        if (emit_empty) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      hvld_q     <= '0;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      rem_q      <= '0;
      sc_q       <= '0;
      lk_pend_q  <= 1'b0;
      p1_vld_q   <= 1'b0;
      p2_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      hvld_q     <= hvld_d;
      cnt_q      <= cnt_d;
      ovf_q      <= ovf_d;
      rem_q      <= rem_d;
      sc_q       <= sc_d;
      lk_pend_q  <= lk_pend_d;
      p1_vld_q   <= p1_vld_d;
      p2_vld_q   <= p1_vld_q;
      best_vld_q <= best_vld_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lk_slot_q <= slot;
    p1_list_q <= sc_idx;
    p2_list_q <= p1_list_q;
    p2_head_q <= head_rdata;
    if (take) begin
      best_q      <= p2_list_q;
      best_head_q <= p2_head_q;
      best_val_q  <= value_rdata;
    end
    if (emit_pop) begin
      m_data_q  <= best_val_q;
      m_last_q  <= (rem_q == CW'(1));
      m_empty_q <= 1'b0;
      m_ovf_q   <= ovf_q;
    end else if (emit_empty) begin
      m_data_q  <= '0;
      m_last_q  <= 1'b1;
      m_empty_q <= 1'b1;
      m_ovf_q   <= ovf_q;
    end
  end

  assign m_axis_tvalid_o                        = m_valid_q;
  assign m_axis_tdata_o                         = m_data_q;
  assign m_axis_tlast_o                         = m_last_q;
  assign m_axis_tuser_o[kwm_pkg::M_TUSER_EMPTY] = m_empty_q;
  assign m_axis_tuser_o[kwm_pkg::M_TUSER_OVF]   = m_ovf_q;

endmodule

// ===== sv/kwm_checker.sv =====
module kwm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_tvalid_i,
  input logic                          s_tready_i,
  input logic                          s_tlast_i,
  input logic                          m_tvalid_i,
  input logic                          m_tready_i,
  input logic [kwm_pkg::M_TDATA_W-1:0] m_tdata_i,
  input logic [kwm_pkg::M_TUSER_W-1:0] m_tuser_i,
  input logic                          m_tlast_i
);

  // end of set closes the input until the merge is through
  a_end_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i && s_tlast_i |=> !s_tready_i)
    else $error("input still open after end of set");

  // only the final result of a set may coexist with an open input
  a_no_load_mid_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tlast_i |-> !s_tready_i)
    else $error("input open while merge results pending");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tuser_i[kwm_pkg::M_TUSER_EMPTY] |-> m_tlast_i)
    else $error("empty-set result without last flag");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i)
      && $stable(m_tlast_i))
    else $error("stalled result changed");

endmodule

bind k_way_sorted_merge_top kwm_checker u_kwm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .s_tlast_i  (s_axis_tlast_i),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o),
  .m_tlast_i  (m_axis_tlast_o)
);
